// ----- design/lzot_pkg.sv -----
// Shared types and constants for the layer z-order table.
package lzot_pkg;

    localparam int MAX_LAYERS_DEF = 256;

    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_SET_HEIGHT = 2'd1,
        OP_FREE       = 2'd2,
        OP_READ_SLOT  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_AREQ,
        S_ACHK,
        S_LREQ,
        S_LCHK,
        S_PLAN,
        S_SREQ,
        S_SWR,
        S_FIN,
        S_REL,
        S_RREQ,
        S_RCAP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic capture;
        logic clr_wr;
        logic a_rd;
        logic a_take;
        logic a_fail;
        logic a_next;
        logic l_rd;
        logic l_chk;
        logic plan;
        logic s_rd;
        logic s_wr;
        logic fin;
        logic rel;
        logic r_rd;
        logic r_cap;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic clr_last;
        logic id_ok;
        logic slot_ok;
        logic free_bit;
        logic scan_last;
        logic use_hit;
        logic same;
        logic shift_empty;
        logic shift_last;
    } sts_t;

endpackage

// ----- design/lzot_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lzot_ctrl.sv -----
// Sequencer for the layer z-order table: issues datapath commands per operation.
module lzot_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lzot_pkg::sts_t sts,
    output lzot_pkg::cmd_t cmd
);

    lzot_pkg::state_t state_reg;
    lzot_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzot_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lzot_pkg::S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = lzot_pkg::S_IDLE;
                end
            end
            lzot_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = lzot_pkg::S_DECODE;
                end
            end
            lzot_pkg::S_DECODE:
            begin
                case (sts.op)
                    lzot_pkg::OP_ALLOC:
                        state_next = lzot_pkg::S_AREQ;
                    lzot_pkg::OP_SET_HEIGHT,
                    lzot_pkg::OP_FREE:
                        state_next = sts.id_ok ? lzot_pkg::S_LREQ : lzot_pkg::S_RESP;
                    lzot_pkg::OP_READ_SLOT:
                        state_next = sts.slot_ok ? lzot_pkg::S_RREQ : lzot_pkg::S_RESP;
                    default:
                        state_next = lzot_pkg::S_RESP;
                endcase
            end
            lzot_pkg::S_AREQ:
                state_next = lzot_pkg::S_ACHK;
            lzot_pkg::S_ACHK:
            begin
                if (sts.free_bit || sts.scan_last)
                begin
                    state_next = lzot_pkg::S_RESP;
                end
                else
                begin
                    state_next = lzot_pkg::S_AREQ;
                end
            end
            lzot_pkg::S_LREQ:
                state_next = lzot_pkg::S_LCHK;
            lzot_pkg::S_LCHK:
            begin
                if (!sts.use_hit)
                begin
                    state_next = lzot_pkg::S_RESP;
                end
                else if (sts.same)
                begin
                    state_next = (sts.op == lzot_pkg::OP_FREE) ? lzot_pkg::S_REL
                                                               : lzot_pkg::S_RESP;
                end
                else
                begin
                    state_next = lzot_pkg::S_PLAN;
                end
            end
            lzot_pkg::S_PLAN:
                state_next = sts.shift_empty ? lzot_pkg::S_FIN : lzot_pkg::S_SREQ;
            lzot_pkg::S_SREQ:
                state_next = lzot_pkg::S_SWR;
            lzot_pkg::S_SWR:
                state_next = sts.shift_last ? lzot_pkg::S_FIN : lzot_pkg::S_SREQ;
            lzot_pkg::S_FIN:
                state_next = (sts.op == lzot_pkg::OP_FREE) ? lzot_pkg::S_REL
                                                           : lzot_pkg::S_RESP;
            lzot_pkg::S_REL:
                state_next = lzot_pkg::S_RESP;
            lzot_pkg::S_RREQ:
                state_next = lzot_pkg::S_RCAP;
            lzot_pkg::S_RCAP:
                state_next = lzot_pkg::S_RESP;
            lzot_pkg::S_RESP:
                state_next = lzot_pkg::S_IDLE;
            default:
                state_next = lzot_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.busy = 1'b1;
        case (state_reg)
            lzot_pkg::S_CLEAR:
                cmd.clr_wr = 1'b1;
            lzot_pkg::S_IDLE:
            begin
                cmd.busy    = 1'b0;
                cmd.capture = start;
            end
            lzot_pkg::S_AREQ:
                cmd.a_rd = 1'b1;
            lzot_pkg::S_ACHK:
            begin
                if (sts.free_bit)
                begin
                    cmd.a_take = 1'b1;
                end
                else if (sts.scan_last)
                begin
                    cmd.a_fail = 1'b1;
                end
                else
                begin
                    cmd.a_next = 1'b1;
                end
            end
            lzot_pkg::S_LREQ:
                cmd.l_rd = 1'b1;
            lzot_pkg::S_LCHK:
                cmd.l_chk = 1'b1;
            lzot_pkg::S_PLAN:
                cmd.plan = 1'b1;
            lzot_pkg::S_SREQ:
                cmd.s_rd = 1'b1;
            lzot_pkg::S_SWR:
                cmd.s_wr = 1'b1;
            lzot_pkg::S_FIN:
                cmd.fin = 1'b1;
            lzot_pkg::S_REL:
                cmd.rel = 1'b1;
            lzot_pkg::S_RREQ:
                cmd.r_rd = 1'b1;
            lzot_pkg::S_RCAP:
                cmd.r_cap = 1'b1;
            lzot_pkg::S_RESP:
                cmd.done = 1'b1;
            default:
                cmd.busy = 1'b1;
        endcase
    end

endmodule

// ----- design/lzot_dp.sv -----
// Datapath for the layer z-order table: layer tables, stack shifter and result registers.
module lzot_dp #(
    parameter int MAX_LAYERS = lzot_pkg::MAX_LAYERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lzot_pkg::cmd_t     cmd,
    output lzot_pkg::sts_t     sts,
    input  logic [1:0]         operation,
    input  logic [7:0]         layer_id,
    input  logic signed [9:0]  requested_height,
    output logic               status,
    output logic [7:0]         result_layer,
    output logic signed [8:0]  new_height,
    output logic signed [8:0]  top_height,
    output logic               redraw_needed
);

    localparam int ID_W  = $clog2(MAX_LAYERS);
    localparam int HW    = ID_W + 1;
    localparam int CW    = (HW + 1 > 10) ? HW + 1 : 10;
    localparam int IDC_W = (ID_W + 1 > 8) ? ID_W + 1 : 8;

    localparam logic [ID_W-1:0]      LAST_IDX = ID_W'(MAX_LAYERS - 1);
    localparam logic [IDC_W-1:0]     MAX_C    = IDC_W'(MAX_LAYERS);
    localparam logic signed [HW-1:0] HIDDEN_H = '1;
    localparam logic signed [HW-1:0] ONE_H    = HW'(1);
    localparam logic signed [CW-1:0] ONE_C    = CW'(1);
    localparam logic signed [CW-1:0] HIDDEN_C = '1;

    lzot_pkg::op_t        op_reg, op_next;
    logic [7:0]           id_reg, id_next;
    logic signed [9:0]    req_reg, req_next;
    logic [ID_W-1:0]      clr_reg, clr_next;
    logic [ID_W-1:0]      scan_reg, scan_next;
    logic signed [HW-1:0] top_reg, top_next;
    logic signed [HW-1:0] old_reg, old_next;
    logic signed [HW-1:0] want_reg, want_next;
    logic [ID_W-1:0]      s_reg, s_next;
    logic [ID_W-1:0]      end_reg, end_next;
    logic                 dir_down_reg, dir_down_next;
    logic                 status_reg, status_next;
    logic [ID_W-1:0]      layer_reg, layer_next;
    logic signed [HW-1:0] height_reg, height_next;
    logic                 redraw_reg, redraw_next;

    logic                 use_we, use_wd, use_rd;
    logic [ID_W-1:0]      use_wa, use_ra;
    logic                 hgt_we;
    logic [ID_W-1:0]      hgt_wa, hgt_ra;
    logic [HW-1:0]        hgt_wd, hgt_rd;
    logic                 stk_we;
    logic [ID_W-1:0]      stk_wa, stk_ra, stk_wd, stk_rd;

    logic [ID_W-1:0]      id_idx, req_idx, src_idx, start_c, end_c;
    logic signed [HW-1:0] old_h, want_h;
    logic signed [CW-1:0] req_c, top_c, lim_c, want_c;
    logic                 plan_down;

    assign id_idx  = ID_W'(id_reg);
    assign req_idx = ID_W'(req_reg);
    assign src_idx = dir_down_reg ? s_reg - ID_W'(1) : s_reg + ID_W'(1);

    assign old_h  = hgt_rd;
    assign req_c  = CW'(req_reg);
    assign top_c  = CW'(top_reg);
    assign lim_c  = old_h[HW-1] ? top_c + ONE_C : top_c;

    always_comb
    begin
        if (op_reg == lzot_pkg::OP_FREE || req_c < HIDDEN_C)
        begin
            want_c = HIDDEN_C;
        end
        else if (req_c > lim_c)
        begin
            want_c = lim_c;
        end
        else
        begin
            want_c = req_c;
        end
    end

    assign want_h = HW'(want_c);

    always_comb
    begin
        if (old_reg[HW-1])
        begin
            plan_down = 1'b1;
            start_c   = ID_W'(top_reg + ONE_H);
            end_c     = want_reg[ID_W-1:0];
        end
        else if (want_reg[HW-1])
        begin
            plan_down = 1'b0;
            start_c   = old_reg[ID_W-1:0];
            end_c     = top_reg[ID_W-1:0];
        end
        else
        begin
            plan_down = (want_reg < old_reg);
            start_c   = old_reg[ID_W-1:0];
            end_c     = want_reg[ID_W-1:0];
        end
    end

    always_comb
    begin
        sts.op          = op_reg;
        sts.clr_last    = (clr_reg == LAST_IDX);
        sts.id_ok       = (IDC_W'(id_reg) < MAX_C);
        sts.slot_ok     = !req_c[CW-1] && (req_c <= top_c);
        sts.free_bit    = !use_rd;
        sts.scan_last   = (scan_reg == LAST_IDX);
        sts.use_hit     = use_rd;
        sts.same        = (want_h == old_h);
        sts.shift_empty = (start_c == end_c);
        sts.shift_last  = (src_idx == end_reg);
    end

    always_comb
    begin
        use_we = cmd.clr_wr || cmd.a_take || cmd.rel;
        use_wd = cmd.a_take;
        use_wa = id_idx;
        if (cmd.clr_wr)
        begin
            use_wa = clr_reg;
        end
        else if (cmd.a_take)
        begin
            use_wa = scan_reg;
        end
        use_ra = cmd.a_rd ? scan_reg : id_idx;

        hgt_we = cmd.a_take || cmd.plan || cmd.s_wr;
        hgt_wa = id_idx;
        hgt_wd = want_reg;
        if (cmd.a_take)
        begin
            hgt_wa = scan_reg;
            hgt_wd = HIDDEN_H;
        end
        else if (cmd.s_wr)
        begin
            hgt_wa = stk_rd;
            hgt_wd = HW'(s_reg);
        end
        hgt_ra = id_idx;

        stk_we = cmd.s_wr || (cmd.fin && !want_reg[HW-1]);
        stk_wa = cmd.s_wr ? s_reg : want_reg[ID_W-1:0];
        stk_wd = cmd.s_wr ? stk_rd : id_idx;
        stk_ra = cmd.s_rd ? src_idx : req_idx;
    end

    always_comb
    begin
        op_next       = op_reg;
        id_next       = id_reg;
        req_next      = req_reg;
        clr_next      = clr_reg;
        scan_next     = scan_reg;
        top_next      = top_reg;
        old_next      = old_reg;
        want_next     = want_reg;
        s_next        = s_reg;
        end_next      = end_reg;
        dir_down_next = dir_down_reg;
        status_next   = status_reg;
        layer_next    = layer_reg;
        height_next   = height_reg;
        redraw_next   = redraw_reg;

        if (cmd.clr_wr)
        begin
            clr_next = clr_reg + ID_W'(1);
        end
        if (cmd.capture)
        begin
            op_next     = lzot_pkg::op_t'(operation);
            id_next     = layer_id;
            req_next    = requested_height;
            scan_next   = '0;
            status_next = 1'b0;
            layer_next  = '0;
            height_next = HIDDEN_H;
            redraw_next = 1'b0;
        end
        if (cmd.a_next)
        begin
            scan_next = scan_reg + ID_W'(1);
        end
        if (cmd.a_take)
        begin
            layer_next = scan_reg;
        end
        if (cmd.a_fail)
        begin
            status_next = 1'b1;
        end
        if (cmd.l_chk)
        begin
            old_next  = old_h;
            want_next = want_h;
            if (use_rd)
            begin
                height_next = want_h;
            end
        end
        if (cmd.plan)
        begin
            s_next        = start_c;
            end_next      = end_c;
            dir_down_next = plan_down;
        end
        if (cmd.s_wr)
        begin
            s_next = src_idx;
        end
        if (cmd.fin)
        begin
            redraw_next = 1'b1;
            if (want_reg[HW-1])
            begin
                top_next = top_reg - ONE_H;
            end
            else if (old_reg[HW-1])
            begin
                top_next = top_reg + ONE_H;
            end
        end
        if (cmd.r_cap)
        begin
            layer_next  = stk_rd;
            height_next = HW'(req_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            top_reg <= HIDDEN_H;
        end
        else
        begin
            clr_reg <= clr_next;
            top_reg <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        req_reg      <= req_next;
        scan_reg     <= scan_next;
        old_reg      <= old_next;
        want_reg     <= want_next;
        s_reg        <= s_next;
        end_reg      <= end_next;
        dir_down_reg <= dir_down_next;
        status_reg   <= status_next;
        layer_reg    <= layer_next;
        height_reg   <= height_next;
        redraw_reg   <= redraw_next;
    end

    lzot_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LAYERS)
    ) u_use_ram (
        .clk   (clk),
        .we    (use_we),
        .waddr (use_wa),
        .wdata (use_wd),
        .raddr (use_ra),
        .rdata (use_rd)
    );

    lzot_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_LAYERS)
    ) u_hgt_ram (
        .clk   (clk),
        .we    (hgt_we),
        .waddr (hgt_wa),
        .wdata (hgt_wd),
        .raddr (hgt_ra),
        .rdata (hgt_rd)
    );

    lzot_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_LAYERS)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_wa),
        .wdata (stk_wd),
        .raddr (stk_ra),
        .rdata (stk_rd)
    );

    assign status        = status_reg;
    assign result_layer  = 8'(layer_reg);
    assign new_height    = 9'(height_reg);
    assign top_height    = 9'(top_reg);
    assign redraw_needed = redraw_reg;

endmodule

// ----- design/layer_z_order_table.sv -----
// Top level of the layer z-order table: controller plus datapath.
//
//  channel   direction  transfer when        fields
//  command   in         start && !busy      operation, layer_id, requested_height
//  result    out        done (one cycle)    status, result_layer, new_height,
//                                           top_height, redraw_needed
//
// After reset the in-use table is swept clear, with busy high.
// Allocate scans upward from layer 0 for the lowest free layer.
// Set height and free shift the stack slots between the old and new height when
// the stack moves, and shift nothing otherwise; free adds a release step.
// Rejected commands go straight to the result. Each shifted stack slot is one
// RAM read followed by one write.
// The result shows for the single cycle done is high; the receiver cannot stall it.
module layer_z_order_table #(
    parameter int MAX_LAYERS = lzot_pkg::MAX_LAYERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [7:0]        layer_id,
    input  logic signed [9:0] requested_height,
    output logic              done,
    output logic              status,
    output logic [7:0]        result_layer,
    output logic signed [8:0] new_height,
    output logic signed [8:0] top_height,
    output logic              redraw_needed
);

    lzot_pkg::cmd_t cmd;
    lzot_pkg::sts_t sts;

    lzot_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd)
    );

    lzot_dp #(
        .MAX_LAYERS (MAX_LAYERS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .layer_id         (layer_id),
        .requested_height (requested_height),
        .status           (status),
        .result_layer     (result_layer),
        .new_height       (new_height),
        .top_height       (top_height),
        .redraw_needed    (redraw_needed)
    );

    assign busy = cmd.busy;
    assign done = cmd.done;

endmodule

// ----- design/lzot_chk.sv -----
// Port-level checks for the layer z-order table, bound to the top level.
module lzot_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              status,
    input logic [7:0]        result_layer,
    input logic signed [8:0] new_height,
    input logic              redraw_needed
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a busy period");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("command transfer not followed by a busy cycle");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (result_layer == 8'd0 && new_height == -9'sd1 && !redraw_needed))
        else $error("pool-full result carries stray fields");

endmodule

bind layer_z_order_table lzot_chk u_lzot_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .result_layer  (result_layer),
    .new_height    (new_height),
    .redraw_needed (redraw_needed)
);
